// ===== rtl/aarm_pkg.sv =====
// Shared constants, types and the arctangent table for the rotation-matrix pipeline.
package aarm_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int CW           = 34;   // CORDIC datapath width, Q2.30 plus guard
  localparam int ZW           = 31;   // reduced-angle bits
  localparam int RW           = 31;   // square-root result bits
  localparam int QW_T         = 34;   // term quotient bits
  localparam int NUMW         = 64;   // term numerator width
  localparam int DENW         = 32;   // term divisor width
  localparam int PW           = 45;   // angle-to-radian product width
  localparam int NTERM        = 9;
  localparam int SUMW         = 36;
  localparam int RECIP_SH     = 24;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW:0]   ONE_Q30     = 35'sd1073741824;
  localparam logic [PW-1:0]        PI_Q30      = 45'd3373259426;
  // pi*2^30 = 11520 * RAD_Q + RAD_R
  localparam logic [18:0]          RAD_Q       = 19'd292817;
  localparam logic [12:0]          RAD_R       = 13'd7586;
  localparam logic [12:0]          RAD_HALF    = 13'd5760;
  // ceil(2^24 / 45), exact floor division for dividends below 2^18
  localparam logic [18:0]          RECIP45     = 19'd372828;
  localparam logic [17:0]          TURN_BIAS   = 18'd46080;
  localparam logic [17:0]          TURN1       = 18'd23040;
  localparam logic [17:0]          TURN2       = 18'd46080;
  localparam logic [17:0]          TURN3       = 18'd69120;
  localparam logic [14:0]          QUARTER1    = 15'd5760;
  localparam logic [14:0]          QUARTER2    = 15'd11520;
  localparam logic [14:0]          QUARTER3    = 15'd17280;
  localparam logic signed [15:0]   Q14_ONE     = 16'sd16384;

  // term order inside the divider bank
  localparam int T_XX = 0;
  localparam int T_YY = 1;
  localparam int T_ZZ = 2;
  localparam int T_XY = 3;
  localparam int T_XZ = 4;
  localparam int T_YZ = 5;
  localparam int T_XS = 6;
  localparam int T_YS = 7;
  localparam int T_ZS = 8;

  typedef enum logic [1:0] {
    QUAD0 = 2'd0,
    QUAD1 = 2'd1,
    QUAD2 = 2'd2,
    QUAD3 = 2'd3
  } quad_e;

  typedef struct packed {
    quad_e              quad;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [31:0]        l2;
  } ang_side_t;

  typedef struct packed {
    quad_e              quad;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [31:0]        l2;
    logic [RW-1:0]      n;
  } cor_side_t;

  typedef struct packed {
    logic                 neg;
    logic signed [CW-1:0] c;
    logic                 zero;
  } res_side_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    unique case (i)
      0:  v = 34'sh03243F6A8;
      1:  v = 34'sh01DAC6705;
      2:  v = 34'sh00FADBAFC;
      3:  v = 34'sh007F56EA6;
      4:  v = 34'sh003FEAB76;
      5:  v = 34'sh001FFD55B;
      6:  v = 34'sh000FFFAAA;
      7:  v = 34'sh0007FFF55;
      8:  v = 34'sh0003FFFEA;
      9:  v = 34'sh0001FFFFD;
      10: v = 34'sh0000FFFFF;
      11: v = 34'sh00007FFFF;
      12: v = 34'sh00003FFFF;
      13: v = 34'sh00001FFFF;
      14: v = 34'sh00000FFFF;
      15: v = 34'sh000007FFF;
      16: v = 34'sh000003FFF;
      17: v = 34'sh000001FFF;
      18: v = 34'sh000000FFF;
      19: v = 34'sh0000007FF;
      20: v = 34'sh0000003FF;
      21: v = 34'sh0000001FF;
      22: v = 34'sh0000000FF;
      23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/aarm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with valid and sideband.
module aarm_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 34,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [NW-1:0] rem_in, rem_d;
    logic [QW-1:0] quo_in, quo_d;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    assign ge = (rem_in >> K) >= NW'(den_in);

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (ge) begin
        rem_d    = rem_in - (NW'(den_in) << K);
        quo_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== rtl/aarm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module aarm_sqrt #(
  parameter int RB = 31
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RB-1:0] rad_i,
  output logic [RB-1:0]   root_o
);

  logic [2*RB-1:0] rem_q  [RB];
  logic [RB-1:0]   root_q [RB];

  for (genvar j = 0; j < RB; j++) begin : g_stage
    localparam int I = RB - 1 - j;
    logic [2*RB-1:0] rem_in, rem_d, trial;
    logic [RB-1:0]   root_in, root_d;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (r + 2^i)^2 - r^2, r has no bits at or below i
    assign trial = ((2*RB)'(root_in) << (I + 1)) | ((2*RB)'(1) << (2 * I));

    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d     = rem_in - trial;
        root_d[I] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end
  end

  assign root_o = root_q[RB-1];

endmodule

// ===== rtl/aarm_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
module aarm_cordic
  import aarm_pkg::*;
#(
  parameter int NIT = 16,
  parameter int SW  = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [ZW-1:0]        z_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [SW-1:0]        side_o
);

  logic signed [CW-1:0] x_q [NIT];
  logic signed [CW-1:0] y_q [NIT];
  logic signed [CW-1:0] z_q [NIT];
  logic [SW-1:0]        side_q [NIT];
  logic                 vld_q [NIT];

  for (genvar j = 0; j < NIT; j++) begin : g_stage
    logic signed [CW-1:0] x_in, y_in, z_in, x_d, y_d, z_d;
    logic [SW-1:0]        side_in;
    logic                 vld_in;

    if (j == 0) begin : g_first
      assign x_in    = CORDIC_GAIN;
      assign y_in    = '0;
      assign z_in    = signed'(CW'(z_i));
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign x_in    = x_q[j-1];
      assign y_in    = y_q[j-1];
      assign z_in    = z_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    always_comb begin
      if (!z_in[CW-1]) begin
        x_d = x_in - (y_in >>> j);
        y_d = y_in + (x_in >>> j);
        z_d = z_in - atan_q30(j);
      end else begin
        x_d = x_in + (y_in >>> j);
        y_d = y_in - (x_in >>> j);
        z_d = z_in + atan_q30(j);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j]    <= x_d;
        y_q[j]    <= y_d;
        z_q[j]    <= z_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NIT-1];
  assign x_o     = x_q[NIT-1];
  assign y_o     = y_q[NIT-1];
  assign side_o  = side_q[NIT-1];

endmodule

// ===== rtl/axis_angle_rotation_matrix.sv =====
// Axis-angle to 3x3 rotation matrix, fully pipelined stream block.
//
//  channel   dir   width  contents
//  s_axis    in    64     axis_x, axis_y, axis_z (Q4.12), angle_deg (1/64 degree)
//  m_axis    out   144+1  r0c0..r2c2 (Q2.14) in tdata, axis_was_zero in tuser
//
// Pipeline stages, with TRIG_ITERATIONS capped at 24: two input stages, the 31-stage
// radian delay line (reciprocal product in its first stage) alongside the 31-stage
// square root, one stage per CORDIC step, four product stages, the 34-stage term
// dividers and two summing stages.
// One item enters per cycle while m_axis does not stall. A stall on m_axis freezes the whole pipeline; nothing
// is dropped. Reset clears the valid bits only.
module axis_angle_rotation_matrix
  import aarm_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // axis_x, axis_y, axis_z, angle_deg
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2
  output logic         m_axis_tuser    // axis_was_zero
);

  localparam int NIT = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: angle reduction to quadrant and remainder
  logic [17:0] ang_u, m_full;
  logic [14:0] m_red;
  quad_e       quad_d;
  logic [12:0] rem_d;

  assign ang_u = {{2{s_axis_tdata[63]}}, s_axis_tdata[63:48]} + TURN_BIAS;

  always_comb begin
    priority if (ang_u >= TURN3) m_full = ang_u - TURN3;
    else if (ang_u >= TURN2)     m_full = ang_u - TURN2;
    else if (ang_u >= TURN1)     m_full = ang_u - TURN1;
    else                         m_full = ang_u;
    m_red = m_full[14:0];
    priority if (m_red >= QUARTER3) begin
      quad_d = QUAD3;
      rem_d  = 13'(m_red - QUARTER3);
    end else if (m_red >= QUARTER2) begin
      quad_d = QUAD2;
      rem_d  = 13'(m_red - QUARTER2);
    end else if (m_red >= QUARTER1) begin
      quad_d = QUAD1;
      rem_d  = 13'(m_red - QUARTER1);
    end else begin
      quad_d = QUAD0;
      rem_d  = 13'(m_red);
    end
  end

  logic               v1_q;
  quad_e              quad1_q;
  logic [12:0]        rem1_q;
  logic signed [15:0] ax1_q, ay1_q, az1_q;

  // stage 2: radian parts and squared length
  logic               v2_q;
  logic [ZW-1:0]      zh2_q;
  logic [17:0]        zb2_q;
  logic [31:0]        l2_2_q;
  ang_side_t          side2_q;
  logic [31:0]        sqx, sqy, sqz;

  assign sqx = 32'(ax1_q * ax1_q);
  assign sqy = 32'(ay1_q * ay1_q);
  assign sqz = 32'(az1_q * az1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quad1_q      <= quad_d;
      rem1_q       <= rem_d;
      ax1_q        <= s_axis_tdata[15:0];
      ay1_q        <= s_axis_tdata[31:16];
      az1_q        <= s_axis_tdata[47:32];
      // split r*pi/11520 into a whole part and a small remainder fraction
      zh2_q        <= ZW'(rem1_q) * ZW'(RAD_Q);
      zb2_q        <= 18'((26'(rem1_q) * 26'(RAD_R) + 26'(RAD_HALF)) >> 8);
      l2_2_q       <= sqx + sqy + sqz;
      side2_q.quad <= quad1_q;
      side2_q.ax   <= ax1_q;
      side2_q.ay   <= ay1_q;
      side2_q.az   <= az1_q;
      side2_q.l2   <= sqx + sqy + sqz;
    end
  end

  // radian conversion delayed to match the norm
  logic          vz;
  logic [ZW-1:0] zrad;
  ang_side_t     side_z;
  logic [RW-1:0] norm;
  logic [36:0]   zfrac;
  logic [ZW-1:0] z_first;
  logic          zv_q [RW];
  logic [ZW-1:0] zd_q [RW];
  ang_side_t     zs_q [RW];

  // remaining divide by 11520: drop 2^8, then reciprocal of 45
  assign zfrac   = 37'(zb2_q) * 37'(RECIP45);
  assign z_first = zh2_q + ZW'(zfrac >> RECIP_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RW; k++) begin
        zv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      zv_q[0] <= v2_q;
      for (int k = 1; k < RW; k++) begin
        zv_q[k] <= zv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zd_q[0] <= z_first;
      zs_q[0] <= side2_q;
      for (int k = 1; k < RW; k++) begin
        zd_q[k] <= zd_q[k-1];
        zs_q[k] <= zs_q[k-1];
      end
    end
  end

  assign vz     = zv_q[RW-1];
  assign zrad   = zd_q[RW-1];
  assign side_z = zs_q[RW-1];

  aarm_sqrt #(.RB(RW)) u_sqrt (
    .clk_i, .en_i(adv), .rad_i({l2_2_q, 30'b0}), .root_o(norm)
  );

  cor_side_t cside_in, cside_out;
  assign cside_in = '{quad: side_z.quad, ax: side_z.ax, ay: side_z.ay, az: side_z.az,
                      l2: side_z.l2, n: norm};

  logic                 vc;
  logic signed [CW-1:0] cx, cy;

  aarm_cordic #(.NIT(NIT), .SW($bits(cor_side_t))) u_cordic (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(vz), .z_i(zrad), .side_i(cside_in),
    .valid_o(vc), .x_o(cx), .y_o(cy), .side_o(cside_out)
  );

  // stage 3: quadrant map
  logic signed [CW-1:0] c_d, s_d;
  always_comb begin
    unique case (cside_out.quad)
      QUAD0: begin c_d = cx;  s_d = cy;  end
      QUAD1: begin c_d = -cy; s_d = cx;  end
      QUAD2: begin c_d = -cx; s_d = -cy; end
      QUAD3: begin c_d = cy;  s_d = -cx; end
      default: begin c_d = cx; s_d = cy; end
    endcase
  end

  logic                 v3_q, v4_q, v5_q, v6_q;
  logic signed [CW-1:0] c3_q, s3_q, c4_q, c5_q, c6_q;
  logic signed [CW:0]   t3_q, t4_q;
  logic signed [15:0]   ax3_q, ay3_q, az3_q;
  logic [31:0]          l2_3_q, l2_4_q, l2_5_q;
  logic [RW-1:0]        n3_q, n4_q, n5_q;
  logic                 z3_q, z4_q, z5_q, z6_q;
  logic signed [31:0]   pab_q [6];
  logic signed [49:0]   pas_q [3];
  logic signed [NUMW-1:0] num_q [NTERM];
  logic [NUMW-1:0]      mag_q [NTERM];
  logic [DENW-1:0]      den6_q [NTERM];
  logic                 neg6_q [NTERM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v3_q <= vc;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 3
      c3_q   <= c_d;
      s3_q   <= s_d;
      t3_q   <= ONE_Q30 - (CW+1)'(c_d);
      ax3_q  <= cside_out.ax;
      ay3_q  <= cside_out.ay;
      az3_q  <= cside_out.az;
      l2_3_q <= cside_out.l2;
      n3_q   <= cside_out.n;
      z3_q   <= (cside_out.l2 == '0);
      // stage 4: axis products
      pab_q[T_XX] <= ax3_q * ax3_q;
      pab_q[T_YY] <= ay3_q * ay3_q;
      pab_q[T_ZZ] <= az3_q * az3_q;
      pab_q[T_XY] <= ax3_q * ay3_q;
      pab_q[T_XZ] <= ax3_q * az3_q;
      pab_q[T_YZ] <= ay3_q * az3_q;
      pas_q[0]    <= 50'(ax3_q) * 50'(s3_q);
      pas_q[1]    <= 50'(ay3_q) * 50'(s3_q);
      pas_q[2]    <= 50'(az3_q) * 50'(s3_q);
      c4_q   <= c3_q;
      t4_q   <= t3_q;
      l2_4_q <= l2_3_q;
      n4_q   <= n3_q;
      z4_q   <= z3_q;
      // stage 5: scale by t and by 2^15
      for (int k = 0; k < 6; k++) begin
        num_q[k] <= NUMW'(NUMW'(pab_q[k]) * NUMW'(t4_q));
      end
      for (int k = 0; k < 3; k++) begin
        num_q[T_XS + k] <= NUMW'(pas_q[k]) <<< 15;
      end
      c5_q   <= c4_q;
      l2_5_q <= l2_4_q;
      n5_q   <= n4_q;
      z5_q   <= z4_q;
      // stage 6: magnitude plus half divisor for round-half-away
      for (int k = 0; k < NTERM; k++) begin
        if (k < T_XS) begin
          den6_q[k] <= l2_5_q;
          mag_q[k]  <= num_q[k][NUMW-1] ? NUMW'(l2_5_q >> 1) - NUMW'(num_q[k])
                                        : NUMW'(num_q[k]) + NUMW'(l2_5_q >> 1);
        end else begin
          den6_q[k] <= DENW'(n5_q);
          mag_q[k]  <= num_q[k][NUMW-1] ? NUMW'(n5_q >> 1) - NUMW'(num_q[k])
                                        : NUMW'(num_q[k]) + NUMW'(n5_q >> 1);
        end
        neg6_q[k] <= num_q[k][NUMW-1];
      end
      c6_q <= c5_q;
      z6_q <= z5_q;
    end
  end

  // term dividers
  logic              vd;
  logic [QW_T-1:0]   quo [NTERM];
  logic              negd [NTERM];
  res_side_t         lead_in, lead_out;

  assign lead_in = '{neg: neg6_q[0], c: c6_q, zero: z6_q};

  for (genvar g = 0; g < NTERM; g++) begin : g_div
    if (g == 0) begin : g_lead
      aarm_div #(.NW(NUMW), .DW(DENW), .QW(QW_T), .SW($bits(res_side_t))) u_div (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(v6_q), .num_i(mag_q[g]), .den_i(den6_q[g]),
        .side_i(lead_in), .valid_o(vd), .quo_o(quo[g]), .side_o(lead_out)
      );
      assign negd[g] = lead_out.neg;
    end else begin : g_rest
      aarm_div #(.NW(NUMW), .DW(DENW), .QW(QW_T), .SW(1)) u_div (
        .clk_i, .rst_ni, .en_i(adv), .valid_i(v6_q), .num_i(mag_q[g]), .den_i(den6_q[g]),
        .side_i(neg6_q[g]), .valid_o(), .quo_o(quo[g]), .side_o(negd[g])
      );
    end
  end

  // stage 7: signed terms and entry sums in Q2.30
  logic signed [QW_T:0]   term [NTERM];
  logic signed [SUMW-1:0] cw;
  logic signed [SUMW-1:0] sum_d [NTERM];

  always_comb begin
    for (int k = 0; k < NTERM; k++) begin
      term[k] = negd[k] ? -signed'((QW_T+1)'(quo[k])) : signed'((QW_T+1)'(quo[k]));
      if (lead_out.zero) begin
        term[k] = '0;
      end
    end
    cw       = SUMW'(lead_out.c);
    sum_d[0] = cw + SUMW'(term[T_XX]);
    sum_d[1] = SUMW'(term[T_XY]) + SUMW'(term[T_ZS]);
    sum_d[2] = SUMW'(term[T_XZ]) - SUMW'(term[T_YS]);
    sum_d[3] = SUMW'(term[T_XY]) - SUMW'(term[T_ZS]);
    sum_d[4] = cw + SUMW'(term[T_YY]);
    sum_d[5] = SUMW'(term[T_YZ]) + SUMW'(term[T_XS]);
    sum_d[6] = SUMW'(term[T_XZ]) + SUMW'(term[T_YS]);
    sum_d[7] = SUMW'(term[T_YZ]) - SUMW'(term[T_XS]);
    sum_d[8] = cw + SUMW'(term[T_ZZ]);
  end

  logic                   v7_q;
  logic signed [SUMW-1:0] sum_q [NTERM];
  logic                   z7_q;

  function automatic logic signed [15:0] to_q14(input logic signed [SUMW-1:0] v);
    logic signed [SUMW:0] w;
    logic signed [SUMW:0] r;
    logic signed [15:0]   o;
    w = SUMW'(0) + (SUMW+1)'(v);
    if (!w[SUMW]) r = (w + (SUMW+1)'(32768)) >>> 16;
    else          r = -(((SUMW+1)'(32768) - w) >>> 16);
    priority if (r > (SUMW+1)'(Q14_ONE))       o = Q14_ONE;
    else if (r < -(SUMW+1)'(Q14_ONE))          o = -Q14_ONE;
    else                                       o = 16'(r);
    return o;
  endfunction

  logic        out_vld_q;
  logic [15:0] ent_q [NTERM];
  logic        zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v7_q      <= vd;
      out_vld_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NTERM; k++) begin
        sum_q[k] <= sum_d[k];
        ent_q[k] <= to_q14(sum_q[k]);
      end
      z7_q   <= lead_out.zero;
      zero_q <= z7_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = zero_q;
  for (genvar g = 0; g < NTERM; g++) begin : g_out
    assign m_axis_tdata[16*g +: 16] = ent_q[g];
  end

endmodule

// ===== rtl/aarm_chk.sv =====
// Port-level checks for the rotation-matrix block, bound to the top level.
module aarm_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow pipeline advance");

  a_zero_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[31:16] == 16'd0 && m_axis_tdata[47:32] == 16'd0 &&
      m_axis_tdata[63:48] == 16'd0 && m_axis_tdata[95:80] == 16'd0 &&
      m_axis_tdata[111:96] == 16'd0 && m_axis_tdata[127:112] == 16'd0 &&
      m_axis_tdata[15:0] == m_axis_tdata[79:64] &&
      m_axis_tdata[15:0] == m_axis_tdata[143:128])
    else $error("zero-axis item is not a scaled identity");

endmodule

bind axis_angle_rotation_matrix aarm_chk u_aarm_chk (.*);

// ===== sim/axis_angle_rotation_matrix_test.sv =====
// Stream testbench for the axis-angle rotation-matrix block: directed and random items
// checked against a bit-exact predictor.
module axis_angle_rotation_matrix_test;
  import aarm_pkg::*;

  localparam int N_RANDOM    = 730;
  localparam int CALM_AFTER  = 650;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TRIG_STEPS  = 16;

  // last field sits in the lowest bits of tdata
  typedef struct packed {
    logic signed [15:0] ang;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } pose_t;

  typedef struct packed {
    logic [8:0][15:0] ent;
    logic             zero_axis;
  } matrix_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;

  pose_t   pending_poses[$];
  matrix_t expected_matrices[$];
  int      n_sent;
  int      n_taken;
  int      gap_left;
  int      stall_left;
  int      cycles;
  bit      calm;
  bit      failed;

  axis_angle_rotation_matrix #(.TRIG_ITERATIONS(TRIG_STEPS)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic longint div_near(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] round_q14(longint q30);
    longint v;
    v = div_near(q30, 64'sd65536);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  // CORDIC sine/cosine in Q2.30 over the reduced angle
  function automatic void sine_cosine(input longint ang, output longint c, output longint s);
    longint m, r, x, y, z, nx, steps;
    quad_e  q;
    m = ang % 23040;
    if (m < 0) m += 23040;
    q = quad_e'(m / 5760);
    r = m % 5760;
    z = longint'((longint'(r) * longint'(PI_Q30) + 5760) / 11520);
    x = CORDIC_GAIN;
    y = 0;
    steps = (TRIG_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STEPS;
    for (int i = 0; i < steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(atan_q30(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(atan_q30(i));
      end
      x = nx;
    end
    case (q)
      QUAD0: begin c = x;  s = y;  end
      QUAD1: begin c = -y; s = x;  end
      QUAD2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic matrix_t rotation_of(pose_t p);
    matrix_t mt;
    longint  vx, vy, vz, c, s, t, l2, n;
    longint  xx, yy, zz, xy, xz, yz, xs, ys, zs;
    vx = p.ax;
    vy = p.ay;
    vz = p.az;
    sine_cosine(longint'(p.ang), c, s);
    l2 = vx * vx + vy * vy + vz * vz;
    mt = '0;
    if (l2 == 0) begin
      mt.ent[0] = round_q14(c);
      mt.ent[4] = round_q14(c);
      mt.ent[8] = round_q14(c);
      mt.zero_axis = 1'b1;
      return mt;
    end
    t  = (64'sd1 <<< 30) - c;
    n  = longint'(int_sqrt(longint'(l2) << 30));
    xx = div_near(vx * vx * t, l2);
    yy = div_near(vy * vy * t, l2);
    zz = div_near(vz * vz * t, l2);
    xy = div_near(vx * vy * t, l2);
    xz = div_near(vx * vz * t, l2);
    yz = div_near(vy * vz * t, l2);
    xs = div_near(vx * s * 32768, n);
    ys = div_near(vy * s * 32768, n);
    zs = div_near(vz * s * 32768, n);
    mt.ent[0] = round_q14(c + xx);
    mt.ent[1] = round_q14(xy + zs);
    mt.ent[2] = round_q14(xz - ys);
    mt.ent[3] = round_q14(xy - zs);
    mt.ent[4] = round_q14(c + yy);
    mt.ent[5] = round_q14(yz + xs);
    mt.ent[6] = round_q14(xz + ys);
    mt.ent[7] = round_q14(yz - xs);
    mt.ent[8] = round_q14(c + zz);
    return mt;
  endfunction

  function automatic pose_t pose(int x, int y, int z, int a);
    pose_t p;
    p.ax = x[15:0];
    p.ay = y[15:0];
    p.az = z[15:0];
    p.ang = a[15:0];
    return p;
  endfunction

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'h0000;
      1: return 16'($urandom_range(0, 64)) - 16'd32;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // posedge: take input items and predict, take result items and compare
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_matrices.push_back(rotation_of(pose_t'(s_axis_tdata)));
        n_taken <= n_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected item tdata=%h tuser=%b", $time, m_axis_tdata,
                   m_axis_tuser);
          failed = 1'b1;
        end else begin
          matrix_t want;
          want = expected_matrices.pop_front();
          for (int j = 0; j < 9; j++)
            if (m_axis_tdata[16*j +: 16] !== want.ent[j]) begin
              $display("%0t: entry %0d expected %0d got %0d", $time, j,
                       $signed(want.ent[j]), $signed(m_axis_tdata[16*j +: 16]));
              failed = 1'b1;
            end
          if (m_axis_tuser !== want.zero_axis) begin
            $display("%0t: axis_was_zero expected %b got %b", $time, want.zero_axis,
                     m_axis_tuser);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // negedge: feed the next item once the current one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || n_taken == n_sent) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 9);
          s_axis_tvalid <= 1'b0;
        end else if (pending_poses.size() != 0) begin
          s_axis_tdata <= pending_poses.pop_front();
          s_axis_tvalid <= 1'b1;
          n_sent <= n_sent + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int mx, my, mz;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    n_sent = 0;
    n_taken = 0;
    gap_left = 0;
    stall_left = 0;
    cycles = 0;
    calm = 1'b0;
    failed = 1'b0;

    // quadrant boundaries, negative angles, extremes, zero axis
    pending_poses.push_back(pose(4096, 0, 0, 0));
    pending_poses.push_back(pose(0, 4096, 0, 5760));
    pending_poses.push_back(pose(0, 0, 4096, 11520));
    pending_poses.push_back(pose(4096, 4096, 4096, 17280));
    pending_poses.push_back(pose(4096, 0, 0, 23040));
    pending_poses.push_back(pose(0, 0, 0, 0));
    pending_poses.push_back(pose(0, 0, 0, 11520));
    pending_poses.push_back(pose(0, 0, 0, -5760));
    pending_poses.push_back(pose(0, 0, 0, 32767));
    pending_poses.push_back(pose(-32768, -32768, -32768, -32768));
    pending_poses.push_back(pose(32767, 32767, 32767, 32767));
    pending_poses.push_back(pose(-32768, 32767, 0, 1));
    pending_poses.push_back(pose(1, 0, 0, -1));
    pending_poses.push_back(pose(0, -1, 0, 2880));
    pending_poses.push_back(pose(0, 0, -32768, -11520));
    pending_poses.push_back(pose(1, 1, 1, 1000));
    pending_poses.push_back(pose(-4096, 2048, -1024, -17280));
    pending_poses.push_back(pose(100, -7000, 32767, 7777));
    pending_poses.push_back(pose(-1, -1, -1, -23039));
    pending_poses.push_back(pose(32767, -32768, 1, 5759));
    for (int k = 0; k < N_RANDOM; k++) begin
      pose_t p;
      mx = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
      my = (mx == 0) ? 0 : $urandom_range(0, 3);
      mz = (mx == 0) ? 0 : $urandom_range(0, 3);
      p.ax  = rand_comp(mx);
      p.ay  = rand_comp(my);
      p.az  = rand_comp(mz);
      p.ang = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 4) * 5760) : 16'($urandom);
      pending_poses.push_back(p);
    end

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_taken >= CALM_AFTER);
    calm = 1'b1;
    wait (pending_poses.size() == 0 && n_taken == n_sent && expected_matrices.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (!failed && expected_matrices.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
